// ===== design/rrfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RFID reply frame parser.
package rrfp_pkg;

  // Default window size in bytes
  localparam int WINDOW_DEPTH_DEF = 28;

  // Header byte values
  localparam logic [7:0] B0_TYPE_A  = 8'h04;
  localparam logic [7:0] B0_TYPE_B  = 8'h01;
  localparam logic [7:0] B0_TYPE_C  = 8'h03;
  localparam logic [7:0] LEN_8      = 8'd8;
  localparam logic [7:0] LEN_12     = 8'd12;
  localparam logic [7:0] LEN_22     = 8'd22;
  localparam logic [7:0] LEN_28     = 8'd28;
  localparam logic [7:0] B2_FOR_12  = 8'h02;
  localparam logic [7:0] B2_FOR_22  = 8'h03;
  localparam logic [7:0] B2_FOR_28  = 8'h04;
  localparam logic [7:0] B2_ALT_12  = 8'hA1;
  localparam logic [7:0] B3_MARK    = 8'h20;
  localparam logic [7:0] XOR_GOOD   = 8'hFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic push;       // write received byte into the window
    logic clear;      // empty the window
    logic scan;       // advance the window scan
    logic emit_next;  // current ID taken by the receiver
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // scan ends this cycle
    logic have_ids;   // at least one ID recorded for this byte
    logic emit_last;  // ID on the output is the final one
  } dp_stat_t;

endpackage

// ===== design/rrfp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rrfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rrfp_datapath.sv =====
`timescale 1ns / 1ps
// Window buffer, header checks, checksum and ID capture for the frame parser.
module rrfp_datapath #(
  parameter int WINDOW_DEPTH = rrfp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrfp_pkg::dp_cmd_t  cmd,
  output rrfp_pkg::dp_stat_t stat,
  input  logic [7:0]         in_byte,
  output logic [31:0]        out_id,
  output logic               out_last
);
  import rrfp_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = FW + 1;

  // Circular index: sum of two values below the depth wraps once at most
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] dep;
    dep = SW'(WINDOW_DEPTH);
    return (s >= dep) ? AW'(s - dep) : AW'(s);
  endfunction

  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] rd_idx_r;
  logic          vld_r;
  logic [FW-1:0] pidx_r;
  logic [7:0]    b0_r;
  logic [7:0]    len_r;
  logic [7:0]    b4_r;
  logic [31:0]   id_r;
  logic [7:0]    xor_r;
  logic [31:0]   ids_r [2];
  logic [1:0]    cnt_r;
  logic          emit_k_r;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    d;
  logic          full;
  logic          issue;
  logic          pv;
  logic          at_hdr;
  logic          hdr_pass;
  logic          fail_hdr;
  logic          wait_ev;
  logic          at_end;
  logic [7:0]    xor_all;
  logic          good;
  logic          drop1;
  logic          event_any;
  logic [FW-1:0] n_drop;
  logic [FW-1:0] fill_after;
  logic          record;
  logic [1:0]    cnt_nxt;

  // Window storage
  rrfp_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (waddr),
    .wdata (in_byte),
    .raddr (raddr),
    .rdata (d)
  );

  // Addresses: push goes after the last held byte, over the oldest when full
  assign full  = (fill_r == FW'(WINDOW_DEPTH));
  assign waddr = full ? head_r : wrap(SW'(head_r) + SW'(fill_r));
  assign raddr = wrap(SW'(head_r) + SW'(rd_idx_r));
  assign issue = (rd_idx_r < fill_r);

  // Header checks on the byte returned this cycle
  assign pv     = cmd.scan && vld_r;
  assign at_hdr = (pidx_r < FW'(4));

  always_comb begin
    case (pidx_r[1:0])
      2'd0: hdr_pass = (d == B0_TYPE_A) || (d == B0_TYPE_B) || (d == B0_TYPE_C);
      2'd1: hdr_pass = (d == LEN_8) || (d == LEN_12) ||
                       ((b0_r == B0_TYPE_A) && ((d == LEN_22) || (d == LEN_28)));
      2'd2: hdr_pass = (len_r == LEN_8) ||
                       ((b0_r == B0_TYPE_A) &&
                        (((len_r == LEN_12) && (d == B2_FOR_12)) ||
                         ((len_r == LEN_22) && (d == B2_FOR_22)) ||
                         ((len_r == LEN_28) && (d == B2_FOR_28)))) ||
                       ((b0_r == B0_TYPE_B) && (len_r == LEN_12) && (d == B2_ALT_12));
      2'd3: hdr_pass = (d == B3_MARK);
      default: hdr_pass = 1'b0;
    endcase
  end

  assign fail_hdr = pv && at_hdr && !hdr_pass;
  // Prefix consistent so far but not yet complete
  assign wait_ev  = pv && at_hdr && hdr_pass &&
                    (((pidx_r != FW'(3)) && ((pidx_r + FW'(1)) == fill_r)) ||
                     ((pidx_r == FW'(3)) && (8'(fill_r) < len_r)));

  // Frame end and checksum
  assign at_end  = pv && !at_hdr && (8'(pidx_r) == (len_r - 8'd1));
  assign xor_all = xor_r ^ d;
  assign good    = at_end && (xor_all == XOR_GOOD);
  assign drop1   = fail_hdr || (at_end && !good);

  assign event_any  = drop1 || good || wait_ev;
  assign n_drop     = good ? FW'(len_r) : FW'(1);
  assign fill_after = fill_r - n_drop;

  assign record  = good && (b4_r == 8'd0) && ((len_r == LEN_12) || (len_r == LEN_28)) &&
                   (cnt_r != 2'd2);
  assign cnt_nxt = record ? (cnt_r + 2'd1) : cnt_r;

  // Status
  assign stat.scan_done = wait_ev || ((drop1 || good) && (fill_after == '0));
  assign stat.have_ids  = (cnt_nxt != 2'd0);
  assign stat.emit_last = (cnt_r == ({1'b0, emit_k_r} + 2'd1));

  assign out_id   = ids_r[emit_k_r];
  assign out_last = stat.emit_last;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fill_r   <= '0;
      rd_idx_r <= '0;
      vld_r    <= 1'b0;
      cnt_r    <= 2'd0;
      emit_k_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        fill_r <= '0;
      end
      if (cmd.push) begin
        if (full) begin
          head_r <= wrap(SW'(head_r) + SW'(1));
        end else begin
          fill_r <= fill_r + FW'(1);
        end
        rd_idx_r <= '0;
        vld_r    <= 1'b0;
        cnt_r    <= 2'd0;
        emit_k_r <= 1'b0;
      end
      if (cmd.scan) begin
        vld_r    <= issue && !event_any;
        rd_idx_r <= event_any ? '0 : (issue ? rd_idx_r + FW'(1) : rd_idx_r);
        if (drop1 || good) begin
          head_r <= wrap(SW'(head_r) + SW'(n_drop));
          fill_r <= fill_after;
        end
        cnt_r <= cnt_nxt;
      end
      if (cmd.emit_next) begin
        emit_k_r <= ~emit_k_r;
      end
    end
  end

  // Payload registers: header fields, checksum, ID bytes
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pidx_r <= rd_idx_r;
    end
    if (pv) begin
      xor_r <= (pidx_r == '0) ? d : xor_all;
      if (pidx_r == FW'(0)) begin
        b0_r <= d;
      end
      if (pidx_r == FW'(1)) begin
        len_r <= d;
      end
      if (pidx_r == FW'(4)) begin
        b4_r <= d;
      end
      if ((pidx_r >= FW'(7)) && (pidx_r <= FW'(10))) begin
        id_r <= {id_r[23:0], d};
      end
    end
    if (record) begin
      ids_r[cnt_r[0]] <= id_r;
    end
  end

endmodule

// ===== design/rrfp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the frame parser: accept, scan, emit.
module rrfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rrfp_pkg::dp_cmd_t  cmd,
  input  rrfp_pkg::dp_stat_t stat
);
  import rrfp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.push  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.have_ids ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/rfid_reply_frame_parser.sv =====
`timescale 1ns / 1ps
// Top level of the RFID reply frame parser.
//
// Input stream: one transaction per received reader byte. in_tuser = 0 pushes
// in_tdata into the frame window; in_tuser = 1 empties the window.
// Output stream: one transaction per tag ID found, out_tdata is the 32-bit ID
// taken big-endian from frame bytes 7 to 10; out_tlast marks the last ID
// produced by one input byte (at most two IDs per byte).
// Flow: a byte is taken, then the window is scanned through a single RAM
// read port, one byte per cycle. A failed frame candidate drops its first
// byte and the scan restarts at the new oldest byte; a good frame leaves
// the window as a whole. IDs then leave one per cycle while out_tready is
// high.
// One byte is in work at a time: in_tready is low from the push until the
// last ID of that byte has been taken.
// Reset: the window is empty and the block is ready; no clearing pass.
// Stall: a stalled output holds out_tvalid, data and last, and the block
// takes no new input until the IDs are delivered.
module rfid_reply_frame_parser #(
  parameter int WINDOW_DEPTH = rrfp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] tag_id
  output logic        out_tlast
);
  import rrfp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rrfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Window, checks and ID buffer
  rrfp_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_byte  (in_tdata),
    .out_id   (out_tdata),
    .out_last (out_tlast)
  );

endmodule

// ===== design/rrfp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the frame parser, bound to the top level.
module rrfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // Never accepting while results are pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while results pending");

  // A clear produces no result and leaves the block ready
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> in_tready && !out_tvalid)
    else $error("clear did not return to ready");

  // Burst ends exactly at the tlast transaction
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("results continued after last");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result burst ended without last");

endmodule

bind rfid_reply_frame_parser rrfp_checker u_rrfp_checker (.*);
